### hdl/fdl_pkg.sv
// Shared constants, types and entry format for the fractional delay line.
package fdl_pkg;

    // Store and field geometry
    localparam int STORE_DEPTH   = 16384;
    localparam int SAMPLE_BITS   = 24;
    localparam int FRACTION_BITS = 8;
    localparam int DELAY_BITS    = 22;
    localparam int ADDR_BITS     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_BITS = ((SAMPLE_BITS + DELAY_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    // Delay saturation compare width and limit
    localparam int CMP_BITS = (DELAY_BITS > ADDR_BITS + FRACTION_BITS) ?
                              DELAY_BITS : ADDR_BITS + FRACTION_BITS;
    localparam logic [CMP_BITS-1:0] DELAY_LIMIT =
        CMP_BITS'(STORE_DEPTH - 1) << FRACTION_BITS;

    // Address wrap constants
    localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(STORE_DEPTH - 1);
    localparam logic [ADDR_BITS:0]   DEPTH_EXT = (ADDR_BITS + 1)'(STORE_DEPTH);

    // Interpolation arithmetic
    localparam int WEIGHT_BITS = FRACTION_BITS + 2;
    localparam int PROD_BITS   = SAMPLE_BITS + FRACTION_BITS + 2;
    localparam int SUM_BITS    = PROD_BITS + 1;
    localparam logic [FRACTION_BITS:0] FRAC_ONE = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;
    localparam logic signed [SUM_BITS-1:0] ROUND_HALF =
        SUM_BITS'(1) << (FRACTION_BITS - 1);

    // Command queue and result queue sizes (powers of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 4;
    localparam int OPTR_BITS   = $clog2(OUT_DEPTH);

    // One classified item, front to back
    typedef struct packed {
        logic [SAMPLE_BITS-1:0]   sample;
        logic [ADDR_BITS-1:0]     wr_addr;
        logic [ADDR_BITS-1:0]     hi_addr;
        logic [ADDR_BITS-1:0]     lo_addr;
        logic [FRACTION_BITS-1:0] frac;
        logic                     hi_bypass;
        logic                     hi_valid;
        logic                     lo_valid;
    } fdl_entry_t;

    // Queue status toward both sides
    typedef struct packed {
        logic full;
        logic empty;
    } fdl_queue_status_t;

    // Back-end memory sequencer phases
    typedef enum logic [1:0] {
        PH_HI = 2'b01,
        PH_LO = 2'b10
    } fdl_phase_t;

endpackage

### hdl/fdl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                                       aclk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hdl/fdl_queue.sv
// Short command queue between the classifying front end and the back end.
module fdl_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_push,
    input  fdl_pkg::fdl_entry_t       q_in,
    input  logic                      q_pop,
    output fdl_pkg::fdl_entry_t       q_head,
    output fdl_pkg::fdl_queue_status_t q_stat
);

    fdl_pkg::fdl_entry_t            entries_reg [fdl_pkg::QUEUE_DEPTH];
    logic [fdl_pkg::QPTR_BITS-1:0]  wr_ptr_reg;
    logic [fdl_pkg::QPTR_BITS-1:0]  rd_ptr_reg;
    logic [fdl_pkg::QPTR_BITS:0]    count_reg;
    logic [fdl_pkg::QPTR_BITS:0]    count_next;

    // Store pushed entries
    always_ff @(posedge aclk) begin
        if (q_push) begin
            entries_reg[wr_ptr_reg] <= q_in;
        end
    end

    // Track occupancy
    always_comb begin
        case ({q_push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (q_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign q_head       = entries_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (fdl_pkg::QPTR_BITS + 1)'(fdl_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

### hdl/fdl_front.sv
// Front end: accepts input transactions, saturates the delay and forms addresses.
module fdl_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fdl_pkg::S_TDATA_BITS-1:0]  s_tdata,   // sample_in, delay_time
    input  fdl_pkg::fdl_queue_status_t        q_stat,
    output logic                              q_push,
    output fdl_pkg::fdl_entry_t               q_entry
);

    logic [fdl_pkg::ADDR_BITS-1:0]     wp_reg;
    logic [fdl_pkg::ADDR_BITS-1:0]     wp_next;
    logic                              wrapped_reg;
    logic                              wrapped_next;
    logic [fdl_pkg::DELAY_BITS-1:0]    delay;
    logic [fdl_pkg::CMP_BITS-1:0]      delay_ext;
    logic                              over_limit;
    logic [fdl_pkg::ADDR_BITS-1:0]     whole;
    logic [fdl_pkg::FRACTION_BITS-1:0] frac;
    logic [fdl_pkg::ADDR_BITS-1:0]     hi_addr;
    logic [fdl_pkg::ADDR_BITS-1:0]     lo_addr;

    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && s_tready;

    // Saturate the delay and split it into whole and fraction parts
    assign delay      = s_tdata[fdl_pkg::SAMPLE_BITS +: fdl_pkg::DELAY_BITS];
    assign delay_ext  = fdl_pkg::CMP_BITS'(delay);
    assign over_limit = (delay_ext > fdl_pkg::DELAY_LIMIT);
    assign whole      = over_limit ? fdl_pkg::LAST_ADDR
                                   : delay_ext[fdl_pkg::FRACTION_BITS +: fdl_pkg::ADDR_BITS];
    assign frac       = over_limit ? '0 : delay_ext[fdl_pkg::FRACTION_BITS-1:0];

    // Advance the write position; mark the store full once it wraps
    assign wp_next      = (wp_reg == fdl_pkg::LAST_ADDR) ? '0 : wp_reg + 1'b1;
    assign wrapped_next = wrapped_reg || (wp_next == '0);

    // Form the two neighbor addresses, wrapping below zero
    always_comb begin
        if (wp_next >= whole) begin
            hi_addr = wp_next - whole;
        end else begin
            hi_addr = fdl_pkg::ADDR_BITS'({1'b0, wp_next} + fdl_pkg::DEPTH_EXT - {1'b0, whole});
        end
        lo_addr = (hi_addr == '0) ? fdl_pkg::LAST_ADDR : hi_addr - 1'b1;
    end

    // Classify the item: entries never written read as zero
    always_comb begin
        q_entry.sample    = s_tdata[fdl_pkg::SAMPLE_BITS-1:0];
        q_entry.wr_addr   = wp_next;
        q_entry.hi_addr   = hi_addr;
        q_entry.lo_addr   = lo_addr;
        q_entry.frac      = frac;
        q_entry.hi_bypass = (whole == '0);
        q_entry.hi_valid  = wrapped_next || ((hi_addr != '0) && (hi_addr <= wp_next));
        q_entry.lo_valid  = wrapped_next || ((lo_addr != '0) && (lo_addr <= wp_next));
    end

    // Hold the write position between transactions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end else if (q_push) begin
            wp_reg      <= wp_next;
            wrapped_reg <= wrapped_next;
        end
    end

endmodule

### hdl/fdl_back.sv
// Back end: sequences the sample store, interpolates and queues the results.
module fdl_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fdl_pkg::fdl_entry_t               q_head,
    input  fdl_pkg::fdl_queue_status_t        q_stat,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fdl_pkg::M_TDATA_BITS-1:0]  m_tdata    // sample_out
);

    fdl_pkg::fdl_phase_t                    phase_reg;
    fdl_pkg::fdl_phase_t                    phase_next;
    fdl_pkg::fdl_entry_t                    cur_reg;
    logic [fdl_pkg::ADDR_BITS-1:0]          rd_addr;
    logic [fdl_pkg::SAMPLE_BITS-1:0]        rd_data;

    logic [fdl_pkg::SAMPLE_BITS-1:0]        hi_data_reg;
    logic [fdl_pkg::FRACTION_BITS-1:0]      frac_reg;
    logic                                   lo_valid_reg;
    logic                                   c_valid_reg;
    logic [fdl_pkg::SAMPLE_BITS-1:0]        lo_data;
    logic signed [fdl_pkg::WEIGHT_BITS-1:0] w_lo;
    logic signed [fdl_pkg::WEIGHT_BITS-1:0] w_hi;
    logic signed [fdl_pkg::PROD_BITS-1:0]   prod_lo_next;
    logic signed [fdl_pkg::PROD_BITS-1:0]   prod_hi_next;
    logic signed [fdl_pkg::PROD_BITS-1:0]   prod_lo_reg;
    logic signed [fdl_pkg::PROD_BITS-1:0]   prod_hi_reg;
    logic                                   d_valid_reg;
    logic signed [fdl_pkg::SUM_BITS-1:0]    sum;
    logic [fdl_pkg::SAMPLE_BITS-1:0]        result;

    logic [fdl_pkg::SAMPLE_BITS-1:0]        out_mem_reg [fdl_pkg::OUT_DEPTH];
    logic [fdl_pkg::OPTR_BITS-1:0]          out_wr_ptr_reg;
    logic [fdl_pkg::OPTR_BITS-1:0]          out_rd_ptr_reg;
    logic [fdl_pkg::OPTR_BITS:0]            out_count_reg;
    logic [fdl_pkg::OPTR_BITS:0]            out_count_next;
    logic [fdl_pkg::OPTR_BITS:0]            reserved_reg;
    logic [fdl_pkg::OPTR_BITS:0]            reserved_next;
    logic                                   out_accept;

    // Start an item only with a queued entry and room reserved for its result
    assign q_pop = (phase_reg == fdl_pkg::PH_HI) && !q_stat.empty &&
                   (reserved_reg < (fdl_pkg::OPTR_BITS + 1)'(fdl_pkg::OUT_DEPTH));

    // Step the memory sequencer: write and upper read, then lower read
    always_comb begin
        unique case (phase_reg)
            fdl_pkg::PH_HI: phase_next = q_pop ? fdl_pkg::PH_LO : fdl_pkg::PH_HI;
            fdl_pkg::PH_LO: phase_next = fdl_pkg::PH_HI;
            default:        phase_next = fdl_pkg::PH_HI;
        endcase
    end

    assign rd_addr = (phase_reg == fdl_pkg::PH_LO) ? cur_reg.lo_addr : q_head.hi_addr;

    fdl_ram #(
        .WIDTH (fdl_pkg::SAMPLE_BITS),
        .DEPTH (fdl_pkg::STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (q_pop),
        .wr_addr (q_head.wr_addr),
        .wr_data (q_head.sample),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Latch the entry and the upper neighbor
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_head;
        end
        if (phase_reg == fdl_pkg::PH_LO) begin
            if (cur_reg.hi_bypass) begin
                hi_data_reg <= cur_reg.sample;
            end else if (cur_reg.hi_valid) begin
                hi_data_reg <= rd_data;
            end else begin
                hi_data_reg <= '0;
            end
            frac_reg     <= cur_reg.frac;
            lo_valid_reg <= cur_reg.lo_valid;
        end
    end

    // Weight both neighbors
    assign lo_data      = lo_valid_reg ? rd_data : '0;
    assign w_lo         = $signed({2'b00, frac_reg});
    assign w_hi         = $signed({1'b0, fdl_pkg::FRAC_ONE - {1'b0, frac_reg}});
    assign prod_lo_next = $signed(lo_data) * w_lo;
    assign prod_hi_next = $signed(hi_data_reg) * w_hi;

    always_ff @(posedge aclk) begin
        if (c_valid_reg) begin
            prod_lo_reg <= prod_lo_next;
            prod_hi_reg <= prod_hi_next;
        end
    end

    // Round half up and drop the fraction bits
    assign sum    = fdl_pkg::SUM_BITS'(prod_lo_reg) + fdl_pkg::SUM_BITS'(prod_hi_reg) +
                    fdl_pkg::ROUND_HALF;
    assign result = sum[fdl_pkg::FRACTION_BITS +: fdl_pkg::SAMPLE_BITS];

    // Queue the results
    always_ff @(posedge aclk) begin
        if (d_valid_reg) begin
            out_mem_reg[out_wr_ptr_reg] <= result;
        end
    end

    assign out_accept = m_tvalid && m_tready;
    assign m_tvalid   = (out_count_reg != '0);
    assign m_tdata    = fdl_pkg::M_TDATA_BITS'(out_mem_reg[out_rd_ptr_reg]);

    always_comb begin
        case ({d_valid_reg, out_accept})
            2'b10:   out_count_next = out_count_reg + 1'b1;
            2'b01:   out_count_next = out_count_reg - 1'b1;
            default: out_count_next = out_count_reg;
        endcase
        case ({q_pop, out_accept})
            2'b10:   reserved_next = reserved_reg + 1'b1;
            2'b01:   reserved_next = reserved_reg - 1'b1;
            default: reserved_next = reserved_reg;
        endcase
    end

    // Advance control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= fdl_pkg::PH_HI;
            c_valid_reg    <= 1'b0;
            d_valid_reg    <= 1'b0;
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
            reserved_reg   <= '0;
        end else begin
            phase_reg   <= phase_next;
            c_valid_reg <= (phase_reg == fdl_pkg::PH_LO);
            d_valid_reg <= c_valid_reg;
            if (d_valid_reg) begin
                out_wr_ptr_reg <= out_wr_ptr_reg + 1'b1;
            end
            if (out_accept) begin
                out_rd_ptr_reg <= out_rd_ptr_reg + 1'b1;
            end
            out_count_reg <= out_count_next;
            reserved_reg  <= reserved_next;
        end
    end

endmodule

### hdl/fractional_delay_line_core.sv
// Fractional delay line top level: front end, command queue and back end.
// Path: command queue, upper and lower store reads, product registers, then the result queue.
// The single read port of the sample store serves the upper and the lower neighbor in turn,
// so the back end starts no new transaction until the lower read of the last one.
// Reset: synchronous, active low; clears pointers, queues and the write position.
// The store is not swept: entries not yet written since reset read as zero.
module fractional_delay_line_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fdl_pkg::S_TDATA_BITS-1:0]  s_tdata,   // sample_in [23:0], delay_time [45:24]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fdl_pkg::M_TDATA_BITS-1:0]  m_tdata    // sample_out [23:0]
);

    fdl_pkg::fdl_entry_t        q_entry;
    fdl_pkg::fdl_entry_t        q_head;
    fdl_pkg::fdl_queue_status_t q_stat;
    logic                       q_push;
    logic                       bk_pop;

    fdl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    fdl_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_in    (q_entry),
        .q_pop   (bk_pop),
        .q_head  (q_head),
        .q_stat  (q_stat)
    );

    fdl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .q_stat   (q_stat),
        .q_pop    (bk_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Back end never takes from an empty queue
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_pop |-> !q_stat.empty)
        else $error("back end popped an empty queue");

    // Memory sequencer does not start items back to back
    a_pop_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_pop |=> !bk_pop)
        else $error("back end started items in consecutive cycles");

    // No result is presented right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule
